@@ rtl/uart_rx_pkg.sv @@
// Shared types and codes for the UART receive deframer with FIFO.
package uart_rx_pkg;

	localparam int LEVEL_W = 5;

	localparam logic [1:0] FN_EDGE = 2'd0;
	localparam logic [1:0] FN_TICK = 2'd1;
	localparam logic [1:0] FN_POP  = 2'd2;

	localparam logic [1:0] TMR_KEEP    = 2'd0;
	localparam logic [1:0] TMR_QUARTER = 2'd1;
	localparam logic [1:0] TMR_FULL    = 2'd2;
	localparam logic [1:0] TMR_STOP    = 2'd3;

	typedef struct packed {
		logic [1:0] func;
		logic       rx_line;
	} in_beat_t;

	typedef struct packed {
		logic [7:0]         rx_byte;
		logic               byte_valid;
		logic               fifo_empty;
		logic [LEVEL_W-1:0] fifo_level;
		logic [1:0]         timer_cmd;
		logic               receiving;
		logic               overrun;
		logic               frame_stored;
	} out_beat_t;

	typedef struct packed {
		logic [1:0] timer_cmd;
		logic       receiving;
		logic       push;
		logic [7:0] push_byte;
	} dfr_out_t;

	typedef struct packed {
		logic               byte_valid;
		logic               empty;
		logic [LEVEL_W-1:0] level;
		logic               overrun;
		logic               stored;
	} fifo_stat_t;

endpackage

@@ rtl/uart_rx_deframer.sv @@
// Receive frame sequencer: start check, data shift, extra tick, stop count, byte store.
module uart_rx_deframer (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  fire,
	input  logic [1:0]            func,
	input  logic                  rx_line,
	input  logic [1:0]            stop_ticks,
	output uart_rx_pkg::dfr_out_t dfr
);
	import uart_rx_pkg::*;

	typedef enum logic [1:0] {PH_START, PH_DATA, PH_EXTRA, PH_STOP} phase_t;

	logic       busy_q, busy_d;
	phase_t     phase_q, phase_d;
	logic [3:0] bits_left_q, bits_left_d;
	logic [1:0] stop_left_q, stop_left_d;
	logic [7:0] shift_q, shift_d;
	logic [1:0] cmd;
	logic       push;

	always_comb begin
		busy_d      = busy_q;
		phase_d     = phase_q;
		bits_left_d = bits_left_q;
		stop_left_d = stop_left_q;
		shift_d     = shift_q;
		cmd         = TMR_KEEP;
		push        = 1'b0;
		if (fire) begin
			case (func)
				FN_EDGE: begin
					if (!busy_q) begin
						busy_d  = 1'b1;
						phase_d = PH_START;
						cmd     = TMR_QUARTER;
					end
				end
				FN_TICK: begin
					if (busy_q) begin
						case (phase_q)
							PH_START: begin
								if (!rx_line) begin
									cmd         = TMR_FULL;
									shift_d     = 8'd0;
									bits_left_d = 4'd8;
									stop_left_d = stop_ticks;
									phase_d     = PH_DATA;
								end else begin
									bits_left_d = 4'd0;
									stop_left_d = 2'd0;
									cmd         = TMR_STOP;
									busy_d      = 1'b0;
								end
							end
							PH_DATA: begin
								if (bits_left_q != 4'd0) begin
									bits_left_d = bits_left_q - 4'd1;
									shift_d     = {rx_line, shift_q[7:1]};
								end else begin
									phase_d = PH_EXTRA;
								end
							end
							PH_EXTRA: begin
								if (stop_left_q != 2'd0)
									stop_left_d = stop_left_q - 2'd1;
								else
									phase_d = PH_STOP;
							end
							PH_STOP: begin
								push    = 1'b1;
								phase_d = PH_START;
								cmd     = TMR_STOP;
								busy_d  = 1'b0;
							end
							default: begin
								phase_d = PH_START;
							end
						endcase
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			phase_q     <= PH_START;
			bits_left_q <= 4'd0;
			stop_left_q <= 2'd0;
			shift_q     <= 8'd0;
		end else begin
			busy_q      <= busy_d;
			phase_q     <= phase_d;
			bits_left_q <= bits_left_d;
			stop_left_q <= stop_left_d;
			shift_q     <= shift_d;
		end
	end

	assign dfr.timer_cmd = cmd;
	assign dfr.receiving = busy_d;
	assign dfr.push      = push;
	assign dfr.push_byte = shift_q;

`ifndef SYNTHESIS
	a_idle_at_start: assert property (@(posedge clk) disable iff (!arst_n)
		!busy_q |-> phase_q == PH_START)
		else $error("idle receiver not in start phase");
	a_store_ends_frame: assert property (@(posedge clk) disable iff (!arst_n)
		push |=> !busy_q && phase_q == PH_START)
		else $error("receiver still busy after store");
	a_bits_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		bits_left_q <= 4'd8)
		else $error("bit counter out of range");
`endif
endmodule

@@ rtl/uart_rx_fifo.sv @@
// Circular receive FIFO with pointers, fill count and registered read port.
module uart_rx_fifo #(
	parameter int DEPTH = 16
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    adv,
	input  logic                    push,
	input  logic [7:0]              push_byte,
	input  logic                    pop,
	output logic [7:0]              rd_byte,
	output uart_rx_pkg::fifo_stat_t stat
);
	import uart_rx_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [7:0]    mem [DEPTH];
	logic [PW-1:0] wptr_q, rptr_q;
	logic [CW-1:0] count_q, count_d;
	logic [7:0]    rd_q;
	logic          push_ok, pop_ok;

	function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
		return (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	assign push_ok = push && (count_q < CW'(DEPTH));
	assign pop_ok  = pop && (count_q != '0);

	always_comb begin
		count_d = count_q;
		if (push_ok)
			count_d = count_q + 1'b1;
		else if (pop_ok)
			count_d = count_q - 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push_ok)
				wptr_q <= ptr_inc(wptr_q);
			if (pop_ok)
				rptr_q <= ptr_inc(rptr_q);
			count_q <= count_d;
		end
	end

	always_ff @(posedge clk) begin
		if (push_ok)
			mem[wptr_q] <= push_byte;
		if (adv)
			rd_q <= pop_ok ? mem[rptr_q] : 8'd0;
	end

	assign rd_byte         = rd_q;
	assign stat.byte_valid = pop_ok;
	assign stat.empty      = pop && !pop_ok;
	assign stat.level      = LEVEL_W'(count_d);
	assign stat.overrun    = push && !push_ok;
	assign stat.stored     = push_ok;

`ifndef SYNTHESIS
	a_count_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("fill count above depth");
	a_empty_ptrs: assert property (@(posedge clk) disable iff (!arst_n)
		count_q == '0 |-> rptr_q == wptr_q)
		else $error("pointers differ on empty FIFO");
	a_push_counts: assert property (@(posedge clk) disable iff (!arst_n)
		push_ok |=> count_q == $past(count_q) + 1'b1)
		else $error("store did not raise fill count");
`endif
endmodule

@@ rtl/uart_rx_tick_deframer_fifo.sv @@
// Top level: input register, receive sequencer, FIFO and result register.
//
// Usage:
//   The input channel (in_valid, in_stall, in_data) carries one event per beat:
//   a falling edge on the line, a bit-time tick with the sampled line level,
//   or a pop from the receive FIFO. Every input beat yields exactly one
//   result beat on the output channel (out_valid, out_stall, out_data) with
//   the popped byte, FIFO status, timer command and receiver state.
//   Each result passes two registers, the input register and then the
//   result register, and out_valid rises when the result register takes
//   it. One beat per cycle is sustained while out_stall is low; the
//   sequencer state and the FIFO pointers update as a beat moves from the
//   input register into the result register, and a pop reads the FIFO
//   memory straight into the result register.
//   cfg_we/cfg_data write the stop-tick count (reset value 1); it is sampled
//   when a start bit is confirmed, so write it while the block is idle.
//   Reset empties the FIFO and idles the receiver; FIFO contents are not
//   cleared. When out_stall is held the result register keeps its beat and
//   in_stall rises once the input register is also full.
module uart_rx_tick_deframer_fifo #(
	parameter int FIFO_DEPTH = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  uart_rx_pkg::in_beat_t  in_data,
	output logic                   out_valid,
	input  logic                   out_stall,
	output uart_rx_pkg::out_beat_t out_data,
	input  logic                   cfg_we,
	input  logic [1:0]             cfg_data
);
	import uart_rx_pkg::*;

	logic       valid_s1;
	in_beat_t   in_s1;
	logic       out_valid_q;
	logic       fire;
	logic [1:0] stop_ticks_q;
	dfr_out_t   dfr;
	fifo_stat_t stat;
	fifo_stat_t stat_q;
	logic [1:0] timer_q;
	logic       recv_q;
	logic [7:0] rd_byte;

	assign fire     = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && out_valid_q && out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1     <= 1'b0;
			out_valid_q  <= 1'b0;
			stop_ticks_q <= 2'd1;
		end else begin
			if (!in_stall)
				valid_s1 <= in_valid;
			if (fire)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
			if (cfg_we)
				stop_ticks_q <= cfg_data;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall)
			in_s1 <= in_data;
		if (fire) begin
			stat_q  <= stat;
			timer_q <= dfr.timer_cmd;
			recv_q  <= dfr.receiving;
		end
	end

	uart_rx_deframer u_dfr (
		.clk        (clk),
		.arst_n     (arst_n),
		.fire       (fire),
		.func       (in_s1.func),
		.rx_line    (in_s1.rx_line),
		.stop_ticks (stop_ticks_q),
		.dfr        (dfr)
	);

	uart_rx_fifo #(
		.DEPTH (FIFO_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (fire),
		.push      (dfr.push),
		.push_byte (dfr.push_byte),
		.pop       (fire && in_s1.func == FN_POP),
		.rd_byte   (rd_byte),
		.stat      (stat)
	);

	assign out_valid             = out_valid_q;
	assign out_data.rx_byte      = rd_byte;
	assign out_data.byte_valid   = stat_q.byte_valid;
	assign out_data.fifo_empty   = stat_q.empty;
	assign out_data.fifo_level   = stat_q.level;
	assign out_data.timer_cmd    = timer_q;
	assign out_data.receiving    = recv_q;
	assign out_data.overrun      = stat_q.overrun;
	assign out_data.frame_stored = stat_q.stored;

`ifndef SYNTHESIS
	a_fire_fills_out: assert property (@(posedge clk) disable iff (!arst_n)
		fire |=> out_valid)
		else $error("processed beat did not reach result register");
	a_no_stall_empty_s1: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> !in_stall)
		else $error("input stalled with empty input register");
	a_store_flags: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(out_data.frame_stored && out_data.overrun))
		else $error("store and overrun in one beat");
`endif
endmodule
